FILE: rtl/core/tangent_frame_inverse_macros.svh
// assertion helpers shared by the rtl
`ifndef TANGENT_FRAME_INVERSE_MACROS_SVH
`define TANGENT_FRAME_INVERSE_MACROS_SVH

// checked only outside reset
`define TFI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define TFI_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/tfi_pkg.sv
package tfi_pkg;

   localparam int NORM_BITS   = 30;
   localparam int ROOT_BITS   = 31;
   localparam int SQUARE_BITS = 62;

   typedef struct packed {
      logic enable;
      logic valid;
   } pipe_ctl_type;

endpackage

FILE: rtl/core/tfi_req_if.sv
interface tfi_req_if #(parameter int COMPONENT_BITS = 16);
   logic                             valid;
   logic                             ready;
   logic signed [COMPONENT_BITS-1:0] normal_x;
   logic signed [COMPONENT_BITS-1:0] normal_y;
   logic signed [COMPONENT_BITS-1:0] normal_z;
   logic signed [COMPONENT_BITS-1:0] tangent_x;
   logic signed [COMPONENT_BITS-1:0] tangent_y;
   logic signed [COMPONENT_BITS-1:0] tangent_z;
   logic signed [1:0]                handedness;

   modport source (
      output valid, normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z,
             handedness,
      input  ready
   );

   modport sink (
      input  valid, normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z,
             handedness,
      output ready
   );
endinterface

FILE: rtl/core/tfi_rsp_if.sv
interface tfi_rsp_if #(parameter int COMPONENT_BITS = 16);
   logic                             valid;
   logic                             ready;
   logic signed [COMPONENT_BITS-1:0] row0_col0;
   logic signed [COMPONENT_BITS-1:0] row0_col1;
   logic signed [COMPONENT_BITS-1:0] row0_col2;
   logic signed [COMPONENT_BITS-1:0] row1_col0;
   logic signed [COMPONENT_BITS-1:0] row1_col1;
   logic signed [COMPONENT_BITS-1:0] row1_col2;
   logic signed [COMPONENT_BITS-1:0] row2_col0;
   logic signed [COMPONENT_BITS-1:0] row2_col1;
   logic signed [COMPONENT_BITS-1:0] row2_col2;
   logic                             degenerate;

   modport source (
      output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
             row2_col0, row2_col1, row2_col2, degenerate,
      input  ready
   );

   modport sink (
      input  valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
             row2_col0, row2_col1, row2_col2, degenerate,
      output ready
   );
endinterface

FILE: rtl/core/tfi_isqrt.sv
module tfi_isqrt
   import tfi_pkg::*;
#(
   parameter int SW = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pipe_ctl_type           ctl,
   input  logic [SQUARE_BITS-1:0] radicand,
   input  logic [SW-1:0]          side_in,
   output logic                   valid_out,
   output logic [ROOT_BITS-1:0]   root,
   output logic [SW-1:0]          side_out
);
   localparam int TW = SQUARE_BITS + 1;

   logic [ROOT_BITS:0]   valid_at;
   logic [TW-1:0]        rem_at  [ROOT_BITS+1];
   logic [ROOT_BITS-1:0] root_at [ROOT_BITS+1];
   logic [SW-1:0]        side_at [ROOT_BITS+1];

   assign valid_at[0] = ctl.valid;
   assign rem_at[0]   = TW'(radicand);
   assign root_at[0]  = '0;
   assign side_at[0]  = side_in;

   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
      localparam int K = ROOT_BITS - 1 - i;
      logic [TW-1:0]        trial;
      logic [TW-1:0]        rem_in;
      logic [ROOT_BITS-1:0] root_in;
      logic                 valid_ff;
      logic [TW-1:0]        rem_ff;
      logic [ROOT_BITS-1:0] root_ff;
      logic [SW-1:0]        side_ff;

      always_comb begin
         trial = (((TW'(root_at[i])) << 1) | (TW'(1) << K)) << K;
         if (rem_at[i] >= trial) begin
            rem_in  = rem_at[i] - trial;
            root_in = root_at[i] | (ROOT_BITS'(1) << K);
         end else begin
            rem_in  = rem_at[i];
            root_in = root_at[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (ctl.enable) begin
            valid_ff <= valid_at[i];
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.enable) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            side_ff <= side_at[i];
         end
      end

      assign valid_at[i+1] = valid_ff;
      assign rem_at[i+1]   = rem_ff;
      assign root_at[i+1]  = root_ff;
      assign side_at[i+1]  = side_ff;
   end

   assign valid_out = valid_at[ROOT_BITS];
   assign root      = root_at[ROOT_BITS];
   assign side_out  = side_at[ROOT_BITS];
endmodule

FILE: rtl/core/tfi_norm.sv
module tfi_norm
   import tfi_pkg::*;
#(
   parameter int VW = 16,
   parameter int FB = 14,
   parameter int SW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pipe_ctl_type         ctl,
   input  logic signed [VW-1:0] vec [3],
   input  logic [SW-1:0]        side_in,
   output logic                 valid_out,
   output logic                 nonzero,
   output logic signed [FB+1:0] unit [3],
   output logic [SW-1:0]        side_out
);
   localparam int JW  = (VW > NORM_BITS) ? VW : NORM_BITS;
   localparam int LS  = $clog2(JW);
   localparam int QB  = FB + 1;
   localparam int NW  = NORM_BITS + QB;
   localparam int UW  = FB + 2;
   localparam int TGW = SW + 3;
   localparam int SQW = 2 * NORM_BITS;
   localparam int IW  = TGW + 1 + 3 * NORM_BITS;

   // magnitudes
   logic [JW-1:0]  mag_in [3];
   logic           mag_valid_ff;
   logic [JW-1:0]  mag_ff [3];
   logic [TGW-1:0] mag_tag_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = JW'(unsigned'(vec[i][VW-1] ? -vec[i] : vec[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
      end else if (ctl.enable) begin
         mag_valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         mag_ff     <= mag_in;
         mag_tag_ff <= {side_in, vec[0][VW-1], vec[1][VW-1], vec[2][VW-1]};
      end
   end

   // left justify, one shift amount per stage
   logic [LS:0]    sh_valid_at;
   logic [JW-1:0]  sh_at     [LS+1][3];
   logic [TGW-1:0] sh_tag_at [LS+1];

   assign sh_valid_at[0] = mag_valid_ff;
   assign sh_at[0]       = mag_ff;
   assign sh_tag_at[0]   = mag_tag_ff;

   for (genvar j = 0; j < LS; j++) begin : g_shift
      localparam int SH = 1 << (LS - 1 - j);
      logic [JW-1:0]  bits_or;
      logic [JW-1:0]  sh_in [3];
      logic           valid_ff;
      logic [JW-1:0]  sh_ff [3];
      logic [TGW-1:0] tag_ff;

      always_comb begin
         bits_or = sh_at[j][0] | sh_at[j][1] | sh_at[j][2];
         for (int i = 0; i < 3; i++) begin
            sh_in[i] = (bits_or[JW-1 -: SH] == '0) ? (sh_at[j][i] << SH) : sh_at[j][i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (ctl.enable) begin
            valid_ff <= sh_valid_at[j];
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.enable) begin
            sh_ff  <= sh_in;
            tag_ff <= sh_tag_at[j];
         end
      end

      assign sh_valid_at[j+1] = valid_ff;
      assign sh_at[j+1]       = sh_ff;
      assign sh_tag_at[j+1]   = tag_ff;
   end

   // top bits, zero test
   logic                 a_valid_ff;
   logic [NORM_BITS-1:0] a_ff [3];
   logic                 a_nz_ff;
   logic [TGW-1:0]       a_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (ctl.enable) begin
         a_valid_ff <= sh_valid_at[LS];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= sh_at[LS][i][JW-1 -: NORM_BITS];
         end
         a_nz_ff  <= sh_at[LS][0][JW-1] | sh_at[LS][1][JW-1] | sh_at[LS][2][JW-1];
         a_tag_ff <= sh_tag_at[LS];
      end
   end

   // squares
   logic                 sq_valid_ff;
   logic [SQW-1:0]       sq_ff [3];
   logic [NORM_BITS-1:0] sq_a_ff [3];
   logic                 sq_nz_ff;
   logic [TGW-1:0]       sq_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (ctl.enable) begin
         sq_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SQW'(a_ff[i]) * SQW'(a_ff[i]);
         end
         sq_a_ff   <= a_ff;
         sq_nz_ff  <= a_nz_ff;
         sq_tag_ff <= a_tag_ff;
      end
   end

   // sum of squares
   logic                   sum_valid_ff;
   logic [SQUARE_BITS-1:0] sum_ff;
   logic [IW-1:0]          sum_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (ctl.enable) begin
         sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         sum_ff      <= SQUARE_BITS'(sq_ff[0]) + SQUARE_BITS'(sq_ff[1])
                      + SQUARE_BITS'(sq_ff[2]);
         sum_side_ff <= {sq_tag_ff, sq_nz_ff, sq_a_ff[0], sq_a_ff[1], sq_a_ff[2]};
      end
   end

   // root
   pipe_ctl_type         isq_ctl;
   logic                 isq_valid;
   logic [ROOT_BITS-1:0] isq_root;
   logic [IW-1:0]        isq_side;

   assign isq_ctl = '{enable: ctl.enable, valid: sum_valid_ff};

   tfi_isqrt #(.SW(IW)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .ctl       (isq_ctl),
      .radicand  (sum_ff),
      .side_in   (sum_side_ff),
      .valid_out (isq_valid),
      .root      (isq_root),
      .side_out  (isq_side)
   );

   // rounded dividends
   logic [NORM_BITS-1:0] isq_a [3];
   logic                 num_valid_ff;
   logic [NW-1:0]        num_ff [3];
   logic [ROOT_BITS-1:0] num_root_ff;
   logic                 num_nz_ff;
   logic [TGW-1:0]       num_tag_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         isq_a[i] = isq_side[(2-i)*NORM_BITS +: NORM_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else if (ctl.enable) begin
         num_valid_ff <= isq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= NW'({isq_a[i], {FB{1'b0}}}) + NW'(isq_root >> 1);
         end
         num_root_ff <= isq_root;
         num_nz_ff   <= isq_side[3*NORM_BITS];
         num_tag_ff  <= isq_side[IW-1 -: TGW];
      end
   end

   // restoring division, one quotient bit per stage
   logic [QB:0]          dv_valid_at;
   logic [ROOT_BITS-1:0] dv_rem_at  [QB+1][3];
   logic [QB-1:0]        dv_low_at  [QB+1][3];
   logic [QB-1:0]        dv_q_at    [QB+1][3];
   logic [ROOT_BITS-1:0] dv_root_at [QB+1];
   logic                 dv_nz_at   [QB+1];
   logic [TGW-1:0]       dv_tag_at  [QB+1];

   assign dv_valid_at[0] = num_valid_ff;
   assign dv_root_at[0]  = num_root_ff;
   assign dv_nz_at[0]    = num_nz_ff;
   assign dv_tag_at[0]   = num_tag_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv_rem_at[0][i] = ROOT_BITS'(num_ff[i][NW-1 -: NORM_BITS]);
         dv_low_at[0][i] = num_ff[i][QB-1:0];
         dv_q_at[0][i]   = '0;
      end
   end

   for (genvar s = 0; s < QB; s++) begin : g_div
      logic [ROOT_BITS:0]   part [3];
      logic [ROOT_BITS-1:0] rem_in [3];
      logic [QB-1:0]        q_in [3];
      logic                 valid_ff;
      logic [ROOT_BITS-1:0] rem_ff [3];
      logic [QB-1:0]        low_ff [3];
      logic [QB-1:0]        q_ff [3];
      logic [ROOT_BITS-1:0] root_ff;
      logic                 nz_ff;
      logic [TGW-1:0]       tag_ff;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            part[i] = {dv_rem_at[s][i], dv_low_at[s][i][QB-1]};
            if (part[i] >= {1'b0, dv_root_at[s]}) begin
               rem_in[i] = ROOT_BITS'(part[i] - {1'b0, dv_root_at[s]});
               q_in[i]   = {dv_q_at[s][i][QB-2:0], 1'b1};
            end else begin
               rem_in[i] = ROOT_BITS'(part[i]);
               q_in[i]   = {dv_q_at[s][i][QB-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (ctl.enable) begin
            valid_ff <= dv_valid_at[s];
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.enable) begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[i] <= rem_in[i];
               low_ff[i] <= dv_low_at[s][i] << 1;
               q_ff[i]   <= q_in[i];
            end
            root_ff <= dv_root_at[s];
            nz_ff   <= dv_nz_at[s];
            tag_ff  <= dv_tag_at[s];
         end
      end

      assign dv_valid_at[s+1] = valid_ff;
      assign dv_rem_at[s+1]   = rem_ff;
      assign dv_low_at[s+1]   = low_ff;
      assign dv_q_at[s+1]     = q_ff;
      assign dv_root_at[s+1]  = root_ff;
      assign dv_nz_at[s+1]    = nz_ff;
      assign dv_tag_at[s+1]   = tag_ff;
   end

   // clamp and sign
   logic [QB-1:0]        q_clamp [3];
   logic signed [UW-1:0] unit_in [3];
   logic                 out_valid_ff;
   logic signed [UW-1:0] unit_ff [3];
   logic                 out_nz_ff;
   logic [SW-1:0]        out_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_clamp[i] = (dv_q_at[QB][i] > (QB'(1) << FB)) ? (QB'(1) << FB) : dv_q_at[QB][i];
         unit_in[i] = dv_tag_at[QB][2-i] ? -signed'(UW'(q_clamp[i]))
                                          : signed'(UW'(q_clamp[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl.enable) begin
         out_valid_ff <= dv_valid_at[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         unit_ff     <= unit_in;
         out_nz_ff   <= dv_nz_at[QB];
         out_side_ff <= dv_tag_at[QB][TGW-1:3];
      end
   end

   assign valid_out = out_valid_ff;
   assign nonzero   = out_nz_ff;
   assign unit      = unit_ff;
   assign side_out  = out_side_ff;
endmodule

FILE: rtl/core/tangent_frame_inverse.sv
// pipeline at the default parameters: three normalise units (5 shift, 31 root and
// 15 quotient stages each) plus 7 arithmetic stages
// throughput: one request per cycle, set by the fully pipelined root and divider stages,
// while the response is not stalled; a stalled response holds the whole pipeline in place
// reset: synchronous, clears every valid bit; data registers are not reset
`include "tangent_frame_inverse_macros.svh"
module tangent_frame_inverse
   import tfi_pkg::*;
#(
   parameter int COMPONENT_BITS = 16,
   parameter int FRACTION_BITS  = 14
) (
   input  logic      clock,
   input  logic      reset,
   tfi_req_if.sink   req_chan,
   tfi_rsp_if.source rsp_chan
);
   localparam int CB   = COMPONENT_BITS;
   localparam int FB   = FRACTION_BITS;
   localparam int UW   = FB + 2;
   localparam int PW   = CB + FB + 2;
   localparam int DW   = CB + 3;
   localparam int RW   = CB + FB + 5;
   localparam int RESW = CB + 3;
   localparam int XW   = 2 * UW;
   localparam int CRW  = 2 * FB + 3;
   localparam int S1W  = 3 * CB + 2;
   localparam int S2W  = 3 * UW + 2;
   localparam int S3W  = 6 * UW + 2;
   localparam int EW   = ((UW > CB) ? UW : CB) + 1;
   localparam logic signed [EW-1:0] LIM = (FB < CB - 1) ? (EW'(1) << FB)
                                                        : ((EW'(1) << (CB - 1)) - EW'(1));

   function automatic logic signed [RW-1:0] round_fb(input logic signed [RW-1:0] x);
      logic [RW-1:0] m;
      m = unsigned'(x[RW-1] ? -x : x);
      m = (m + (RW'(1) << (FB - 1))) >> FB;
      round_fb = x[RW-1] ? -signed'(m) : signed'(m);
   endfunction

   function automatic logic [CB-1:0] pack_comp(input logic signed [UW-1:0] x);
      logic signed [EW-1:0] xe;
      xe = EW'(x);
      if (xe > LIM) begin
         xe = LIM;
      end else if (xe < -LIM) begin
         xe = -LIM;
      end
      pack_comp = xe[CB-1:0];
   endfunction

   logic en;
   logic out_valid_ff;

   assign en             = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // normal
   pipe_ctl_type         n1_ctl;
   logic signed [CB-1:0] n_vec [3];
   logic [S1W-1:0]       n1_side_in;
   logic                 n1_valid;
   logic                 n1_nz;
   logic signed [UW-1:0] n1_unit [3];
   logic [S1W-1:0]       n1_side;
   logic signed [CB-1:0] n1_t [3];

   assign n1_ctl     = '{enable: en, valid: req_chan.valid};
   assign n_vec[0]   = req_chan.normal_x;
   assign n_vec[1]   = req_chan.normal_y;
   assign n_vec[2]   = req_chan.normal_z;
   assign n1_side_in = {req_chan.tangent_x, req_chan.tangent_y, req_chan.tangent_z,
                        req_chan.handedness != 2'sd0, req_chan.handedness[1]};

   tfi_norm #(.VW(CB), .FB(FB), .SW(S1W)) u_norm_n (
      .clock     (clock),
      .reset     (reset),
      .ctl       (n1_ctl),
      .vec       (n_vec),
      .side_in   (n1_side_in),
      .valid_out (n1_valid),
      .nonzero   (n1_nz),
      .unit      (n1_unit),
      .side_out  (n1_side)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n1_t[i] = n1_side[2 + (2-i)*CB +: CB];
      end
   end

   // dot product terms
   logic                 d1_valid_ff;
   logic signed [PW-1:0] d1_prod_ff [3];
   logic signed [UW-1:0] d1_nu_ff [3];
   logic signed [CB-1:0] d1_t_ff [3];
   logic                 d1_ok_ff;
   logic                 d1_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
      end else if (en) begin
         d1_valid_ff <= n1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d1_prod_ff[i] <= PW'(n1_t[i]) * PW'(n1_unit[i]);
         end
         d1_nu_ff  <= n1_unit;
         d1_t_ff   <= n1_t;
         d1_ok_ff  <= n1_nz & n1_side[1];
         d1_neg_ff <= n1_side[0];
      end
   end

   // rounded dot
   logic                 d2_valid_ff;
   logic signed [DW-1:0] d2_dot_ff;
   logic signed [UW-1:0] d2_nu_ff [3];
   logic signed [CB-1:0] d2_t_ff [3];
   logic                 d2_ok_ff;
   logic                 d2_neg_ff;
   logic signed [PW-1:0] dot_sum;

   assign dot_sum = d1_prod_ff[0] + d1_prod_ff[1] + d1_prod_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_valid_ff <= 1'b0;
      end else if (en) begin
         d2_valid_ff <= d1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_dot_ff <= DW'(round_fb(RW'(dot_sum)));
         d2_nu_ff  <= d1_nu_ff;
         d2_t_ff   <= d1_t_ff;
         d2_ok_ff  <= d1_ok_ff;
         d2_neg_ff <= d1_neg_ff;
      end
   end

   // projection
   logic                 p1_valid_ff;
   logic signed [RW-1:0] p1_prod_ff [3];
   logic signed [UW-1:0] p1_nu_ff [3];
   logic signed [CB-1:0] p1_t_ff [3];
   logic                 p1_ok_ff;
   logic                 p1_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= d2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p1_prod_ff[i] <= RW'(d2_nu_ff[i]) * RW'(d2_dot_ff);
         end
         p1_nu_ff  <= d2_nu_ff;
         p1_t_ff   <= d2_t_ff;
         p1_ok_ff  <= d2_ok_ff;
         p1_neg_ff <= d2_neg_ff;
      end
   end

   // residual
   logic                   p2_valid_ff;
   logic signed [RESW-1:0] p2_res_ff [3];
   logic signed [UW-1:0]   p2_nu_ff [3];
   logic                   p2_ok_ff;
   logic                   p2_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p2_res_ff[i] <= RESW'(p1_t_ff[i]) - RESW'(round_fb(p1_prod_ff[i]));
         end
         p2_nu_ff  <= p1_nu_ff;
         p2_ok_ff  <= p1_ok_ff;
         p2_neg_ff <= p1_neg_ff;
      end
   end

   // tangent
   pipe_ctl_type         n2_ctl;
   logic [S2W-1:0]       n2_side_in;
   logic                 n2_valid;
   logic                 n2_nz;
   logic signed [UW-1:0] n2_unit [3];
   logic [S2W-1:0]       n2_side;
   logic signed [UW-1:0] n2_nu [3];

   assign n2_ctl     = '{enable: en, valid: p2_valid_ff};
   assign n2_side_in = {p2_nu_ff[0], p2_nu_ff[1], p2_nu_ff[2], p2_ok_ff, p2_neg_ff};

   tfi_norm #(.VW(RESW), .FB(FB), .SW(S2W)) u_norm_t (
      .clock     (clock),
      .reset     (reset),
      .ctl       (n2_ctl),
      .vec       (p2_res_ff),
      .side_in   (n2_side_in),
      .valid_out (n2_valid),
      .nonzero   (n2_nz),
      .unit      (n2_unit),
      .side_out  (n2_side)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n2_nu[i] = n2_side[2 + (2-i)*UW +: UW];
      end
   end

   // cross product terms
   logic                 x1_valid_ff;
   logic signed [XW-1:0] x1_prod_ff [6];
   logic signed [UW-1:0] x1_nu_ff [3];
   logic signed [UW-1:0] x1_tu_ff [3];
   logic                 x1_ok_ff;
   logic                 x1_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_valid_ff <= 1'b0;
      end else if (en) begin
         x1_valid_ff <= n2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_prod_ff[0] <= XW'(n2_nu[1]) * XW'(n2_unit[2]);
         x1_prod_ff[1] <= XW'(n2_nu[2]) * XW'(n2_unit[1]);
         x1_prod_ff[2] <= XW'(n2_nu[2]) * XW'(n2_unit[0]);
         x1_prod_ff[3] <= XW'(n2_nu[0]) * XW'(n2_unit[2]);
         x1_prod_ff[4] <= XW'(n2_nu[0]) * XW'(n2_unit[1]);
         x1_prod_ff[5] <= XW'(n2_nu[1]) * XW'(n2_unit[0]);
         x1_nu_ff      <= n2_nu;
         x1_tu_ff      <= n2_unit;
         x1_ok_ff      <= n2_side[1] & n2_nz;
         x1_neg_ff     <= n2_side[0];
      end
   end

   logic                  x2_valid_ff;
   logic signed [CRW-1:0] x2_cr_ff [3];
   logic signed [UW-1:0]  x2_nu_ff [3];
   logic signed [UW-1:0]  x2_tu_ff [3];
   logic                  x2_ok_ff;
   logic                  x2_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x2_valid_ff <= 1'b0;
      end else if (en) begin
         x2_valid_ff <= x1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x2_cr_ff[0] <= CRW'(x1_prod_ff[0] - x1_prod_ff[1]);
         x2_cr_ff[1] <= CRW'(x1_prod_ff[2] - x1_prod_ff[3]);
         x2_cr_ff[2] <= CRW'(x1_prod_ff[4] - x1_prod_ff[5]);
         x2_nu_ff    <= x1_nu_ff;
         x2_tu_ff    <= x1_tu_ff;
         x2_ok_ff    <= x1_ok_ff;
         x2_neg_ff   <= x1_neg_ff;
      end
   end

   // bitangent
   pipe_ctl_type         n3_ctl;
   logic [S3W-1:0]       n3_side_in;
   logic                 n3_valid;
   logic                 n3_nz;
   logic signed [UW-1:0] n3_unit [3];
   logic [S3W-1:0]       n3_side;
   logic signed [UW-1:0] n3_nu [3];
   logic signed [UW-1:0] n3_tu [3];

   assign n3_ctl     = '{enable: en, valid: x2_valid_ff};
   assign n3_side_in = {x2_nu_ff[0], x2_nu_ff[1], x2_nu_ff[2],
                        x2_tu_ff[0], x2_tu_ff[1], x2_tu_ff[2], x2_ok_ff, x2_neg_ff};

   tfi_norm #(.VW(CRW), .FB(FB), .SW(S3W)) u_norm_b (
      .clock     (clock),
      .reset     (reset),
      .ctl       (n3_ctl),
      .vec       (x2_cr_ff),
      .side_in   (n3_side_in),
      .valid_out (n3_valid),
      .nonzero   (n3_nz),
      .unit      (n3_unit),
      .side_out  (n3_side)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n3_tu[i] = n3_side[2 + (2-i)*UW +: UW];
         n3_nu[i] = n3_side[2 + (5-i)*UW +: UW];
      end
   end

   // response register
   logic                 frame_ok;
   logic signed [UW-1:0] bu_signed [3];
   logic [CB-1:0]        row_in [9];
   logic [CB-1:0]        row_ff [9];
   logic                 degen_ff;

   assign frame_ok = n3_side[1] & n3_nz;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         bu_signed[i] = n3_side[0] ? -n3_unit[i] : n3_unit[i];
         if (frame_ok) begin
            row_in[i]     = pack_comp(n3_tu[i]);
            row_in[3 + i] = pack_comp(bu_signed[i]);
            row_in[6 + i] = pack_comp(n3_nu[i]);
         end else begin
            row_in[i]     = '0;
            row_in[3 + i] = '0;
            row_in[6 + i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= n3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         row_ff   <= row_in;
         degen_ff <= !frame_ok;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.row0_col0  = row_ff[0];
   assign rsp_chan.row0_col1  = row_ff[1];
   assign rsp_chan.row0_col2  = row_ff[2];
   assign rsp_chan.row1_col0  = row_ff[3];
   assign rsp_chan.row1_col1  = row_ff[4];
   assign rsp_chan.row1_col2  = row_ff[5];
   assign rsp_chan.row2_col0  = row_ff[6];
   assign rsp_chan.row2_col1  = row_ff[7];
   assign rsp_chan.row2_col2  = row_ff[8];
   assign rsp_chan.degenerate = degen_ff;

   `TFI_ASSERT(a_degen_zero, out_valid_ff && degen_ff |-> ((row_ff[0] | row_ff[1] | row_ff[2] | row_ff[3] | row_ff[4] | row_ff[5] | row_ff[6] | row_ff[7] | row_ff[8]) == '0), "degenerate frame with nonzero matrix")
   `TFI_ASSERT(a_stall_holds, n3_valid && !en |=> n3_valid, "stalled frame lost in pipeline")
   `TFI_ASSERT_RST(a_reset_clears, reset |=> !out_valid_ff, "response valid after reset")
endmodule
